[rtl/histogram_specification_lut_core_macros.svh]
// Assertion macros for the histogram specification block.
// Included by the modules that check their own control logic; depends on nothing.
`ifndef HISTOGRAM_SPECIFICATION_LUT_CORE_MACROS_SVH
`define HISTOGRAM_SPECIFICATION_LUT_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define HSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hsl_pkg.sv]
// Shared types and constants for the histogram specification block.
// Used by the top level and the table build engine; depends on nothing.
package hsl_pkg;

    localparam int HSL_NUM_LEVELS = 256;
    localparam int HSL_COUNT_BITS = 22;

    // Item kinds on the input channel
    typedef enum logic [2:0] {
        K_LOAD_SRC = 3'd0,
        K_LOAD_REF = 3'd1,
        K_BUILD    = 3'd2,
        K_MAP      = 3'd3,
        K_CLEAR    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] mapped_sample;
        logic       table_built;
    } t_out_item;

    // Memory requests from the build engine to the top level
    typedef struct packed {
        logic       src_rd_en;
        logic       ref_rd_en;
        logic [7:0] rd_addr;
        logic       map_wr_en;
        logic [7:0] map_addr;
        logic [7:0] map_data;
        logic       done;
    } t_match_req;

endpackage

[rtl/histogram_specification_lut_core.sv]
// Top level of the histogram specification block: item intake, histogram
// update pipeline, memories and result register. Uses hsl_pkg, hsl_ram, hsl_match.
//
//  Channel  | Signals                    | Moves
//  ---------+----------------------------+--------------------------------------
//  input    | i_valid, o_ready, i_item   | kind and sample, one transfer per item
//  output   | o_valid, i_ready, o_item   | mapped_sample and table_built per map
//
// Load, map and unused kinds may follow back to back.
// A map result passes the stage after intake and then the result register before it
// reaches o_valid. A build makes one reference-histogram read per candidate level
// for each source level. After reset, and after a clear, a pass over all NUM_LEVELS
// addresses zeros both histograms with intake held; the pass after reset also loads
// the identity table.
// A map result waiting on i_ready stalls intake only while another map is behind it.
`include "histogram_specification_lut_core_macros.svh"

module histogram_specification_lut_core
    import hsl_pkg::*;
#(
    parameter int NUM_LEVELS = HSL_NUM_LEVELS,
    parameter int COUNT_BITS = HSL_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int CW = COUNT_BITS;
    localparam int IW = $clog2(NUM_LEVELS);
    localparam logic [IW-1:0] TOP_LVL = IW'(NUM_LEVELS - 1);

    // Intake decode
    logic          acc;
    logic          acc_src;
    logic          acc_ref;
    logic          acc_map;
    logic          acc_build;
    logic          acc_clr;
    logic [IW-1:0] in_lvl;

    // Stage after intake
    logic          r_s1_vld;
    logic [2:0]    r_s1_kind;
    logic [IW-1:0] r_s1_lvl;
    logic          s1_src;
    logic          s1_ref;
    logic          s1_map;
    logic          s1_stall;

    // Forwarding of the last count write
    logic          r_fwd_vld;
    logic          r_fwd_ref;
    logic [IW-1:0] r_fwd_lvl;
    logic [CW-1:0] r_fwd_cnt;
    logic          fwd_hit;
    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] n_cnt;

    // Totals and flags
    logic [CW-1:0] r_ns;
    logic [CW-1:0] r_nr;
    logic          r_built;

    // Clearing pass over the histograms, and over the table after reset
    logic          r_wipe_busy;
    logic          r_wipe_map;
    logic [IW-1:0] r_wipe_addr;

    // Memory ports
    logic          src_re;
    logic          ref_re;
    logic [IW-1:0] src_raddr;
    logic [IW-1:0] ref_raddr;
    logic [CW-1:0] src_rdata;
    logic [CW-1:0] ref_rdata;
    logic [CW-1:0] src_cnt;
    logic [CW-1:0] ref_cnt;
    logic [IW-1:0] map_rdata;
    logic          src_we;
    logic          ref_we;
    logic [IW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic          map_we;
    logic [IW-1:0] map_waddr;
    logic [IW-1:0] map_wdata;

    // Result register
    logic          r_out_vld;
    t_out_item     r_out;
    t_out_item     n_out;

    // Build engine
    t_match_req    eng_req;
    logic          eng_busy;

    // Decode the incoming item
    always_comb begin
        acc       = i_valid && o_ready;
        acc_src   = acc && (i_item.kind == K_LOAD_SRC);
        acc_ref   = acc && (i_item.kind == K_LOAD_REF);
        acc_map   = acc && (i_item.kind == K_MAP);
        acc_build = acc && (i_item.kind == K_BUILD);
        acc_clr   = acc && (i_item.kind == K_CLEAR);
        if (int'(i_item.sample) >= NUM_LEVELS) begin
            in_lvl = TOP_LVL;
        end else begin
            in_lvl = i_item.sample[IW-1:0];
        end
    end

    // Stage controls and back pressure
    always_comb begin
        s1_src   = r_s1_vld && (r_s1_kind == K_LOAD_SRC);
        s1_ref   = r_s1_vld && (r_s1_kind == K_LOAD_REF);
        s1_map   = r_s1_vld && (r_s1_kind == K_MAP);
        s1_stall = s1_map && r_out_vld && !i_ready;
        o_ready  = !eng_busy && !s1_stall && !r_wipe_busy;
    end

    // Route histogram reads from intake or from the build engine
    always_comb begin
        src_re    = acc_src || eng_req.src_rd_en;
        ref_re    = acc_ref || eng_req.ref_rd_en;
        src_raddr = eng_busy ? eng_req.rd_addr[IW-1:0] : in_lvl;
        ref_raddr = eng_busy ? eng_req.rd_addr[IW-1:0] : in_lvl;
        src_cnt   = src_rdata;
        ref_cnt   = ref_rdata;
    end

    // Route memory writes from the clearing pass, the count update or the engine
    always_comb begin
        src_we    = s1_src || r_wipe_busy;
        ref_we    = s1_ref || r_wipe_busy;
        cnt_waddr = r_wipe_busy ? r_wipe_addr : r_s1_lvl;
        cnt_wdata = r_wipe_busy ? '0 : n_cnt;
        map_we    = eng_req.map_wr_en || (r_wipe_busy && r_wipe_map);
        map_waddr = r_wipe_busy ? r_wipe_addr : eng_req.map_addr[IW-1:0];
        map_wdata = r_wipe_busy ? r_wipe_addr : eng_req.map_data[IW-1:0];
    end

    // Saturating increment with forwarding from the previous write
    always_comb begin
        fwd_hit = r_fwd_vld && (r_fwd_ref == s1_ref) && (r_fwd_lvl == r_s1_lvl);
        if (fwd_hit) begin
            cur_cnt = r_fwd_cnt;
        end else if (s1_ref) begin
            cur_cnt = ref_cnt;
        end else begin
            cur_cnt = src_cnt;
        end
        n_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + CW'(1);
    end

    // Map result from the table entry
    always_comb begin
        n_out.mapped_sample = 8'(map_rdata);
        n_out.table_built   = r_built;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_ns        <= '0;
            r_nr        <= '0;
            r_built     <= 1'b0;
            r_out_vld   <= 1'b0;
            r_wipe_busy <= 1'b1;
            r_wipe_map  <= 1'b1;
            r_wipe_addr <= '0;
        end else begin
            // Advance or hold the stage after intake
            if (acc) begin
                r_s1_vld  <= 1'b1;
                r_s1_kind <= i_item.kind;
                r_s1_lvl  <= in_lvl;
            end else if (!s1_stall) begin
                r_s1_vld <= 1'b0;
            end

            // Record the count write for the next item
            r_fwd_vld <= (s1_src || s1_ref) && !acc_clr;
            r_fwd_ref <= s1_ref;
            r_fwd_lvl <= r_s1_lvl;
            r_fwd_cnt <= n_cnt;

            // Clear takes effect at its transfer, over any count in flight
            if (acc_clr) begin
                r_ns    <= '0;
                r_nr    <= '0;
                r_built <= 1'b0;
            end else begin
                if (s1_src) begin
                    r_ns <= (&r_ns) ? r_ns : r_ns + CW'(1);
                end
                if (s1_ref) begin
                    r_nr <= (&r_nr) ? r_nr : r_nr + CW'(1);
                end
                if (eng_req.done) begin
                    r_built <= 1'b1;
                end
            end

            // Step the clearing pass; a clear starts one over the histograms only
            if (acc_clr) begin
                r_wipe_busy <= 1'b1;
                r_wipe_map  <= 1'b0;
                r_wipe_addr <= '0;
            end else if (r_wipe_busy) begin
                r_wipe_addr <= r_wipe_addr + IW'(1);
                if (r_wipe_addr == TOP_LVL) begin
                    r_wipe_busy <= 1'b0;
                    r_wipe_map  <= 1'b0;
                end
            end

            // Result register
            if (s1_map && !s1_stall) begin
                r_out_vld <= 1'b1;
                r_out     <= n_out;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    hsl_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_LEVELS)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (src_re),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    hsl_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_LEVELS)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (ref_re),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    hsl_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_LEVELS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (acc_map),
        .i_raddr (in_lvl),
        .o_rdata (map_rdata)
    );

    hsl_match #(
        .NUM_LEVELS (NUM_LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (acc_build),
        .i_ns      (r_ns),
        .i_nr      (r_nr),
        .i_src_cnt (src_cnt),
        .i_ref_cnt (ref_cnt),
        .o_busy    (eng_busy),
        .o_req     (eng_req)
    );

    `HSL_ASSERT_NEXT(a_map_to_out, i_clk, i_rst_n, s1_map && !s1_stall, r_out_vld,
        "map result not presented")
    `HSL_ASSERT_NEXT(a_clear_totals, i_clk, i_rst_n, acc_clr,
        r_ns == '0 && r_nr == '0 && !r_built, "clear did not empty totals")
    `HSL_ASSERT_NEXT(a_done_built, i_clk, i_rst_n, eng_req.done, r_built,
        "build finished without built flag")
    `HSL_ASSERT_NOW(a_wipe_holds_intake, i_clk, i_rst_n, r_wipe_busy, !o_ready,
        "transfer accepted during clearing pass")

endmodule

[rtl/hsl_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// Read during write to the same address returns the old contents. No dependencies.
module hsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/hsl_match.sv]
// Table build engine: walks source levels, scans all reference levels per row,
// and writes the closest reference level into the mapping table. Uses hsl_pkg.
`include "histogram_specification_lut_core_macros.svh"

module hsl_match
    import hsl_pkg::*;
#(
    parameter int NUM_LEVELS = HSL_NUM_LEVELS,
    parameter int COUNT_BITS = HSL_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_ns,
    input  logic [COUNT_BITS-1:0] i_nr,
    input  logic [COUNT_BITS-1:0] i_src_cnt,
    input  logic [COUNT_BITS-1:0] i_ref_cnt,
    output logic                  o_busy,
    output t_match_req            o_req
);

    localparam int CW = COUNT_BITS;
    localparam int PW = 2 * COUNT_BITS;
    localparam int IW = $clog2(NUM_LEVELS);
    localparam int JW = IW + 1;
    localparam logic [IW-1:0] TOP_LVL = IW'(NUM_LEVELS - 1);
    localparam logic [JW-1:0] J_END = JW'(NUM_LEVELS);

    typedef enum logic [2:0] {
        M_IDLE,
        M_SRC_RD,
        M_SRC_ACC,
        M_A_MUL,
        M_SCAN,
        M_WRITE
    } t_state;

    t_state          r_state;
    logic [IW-1:0]   r_i;
    logic [JW-1:0]   r_j;
    logic [CW-1:0]   r_accs;
    logic [CW-1:0]   r_accr;
    logic [PW-1:0]   r_a;
    logic [PW-1:0]   r_b;
    logic [PW-1:0]   r_best;
    logic [IW-1:0]   r_pick;
    logic            r_p1_vld;
    logic            r_p2_vld;
    logic            r_p3_vld;
    logic [IW-1:0]   r_p1_j;
    logic [IW-1:0]   r_p2_j;
    logic [IW-1:0]   r_p3_j;

    logic [CW-1:0]   n_accs;
    logic [CW-1:0]   n_accr;
    logic [PW-1:0]   diff;
    logic            better;
    logic            issue;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    // Running sums and distance of the candidate in the last stage
    always_comb begin
        n_accs = sat_add(r_accs, i_src_cnt);
        n_accr = sat_add(r_accr, i_ref_cnt);
        diff   = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
        better = (r_p3_j == '0) || (diff < r_best);
        issue  = (r_state == M_SCAN) && (r_j != J_END);
    end

    // Memory requests toward the top level
    always_comb begin
        o_req.src_rd_en = (r_state == M_SRC_RD);
        o_req.ref_rd_en = issue;
        o_req.rd_addr   = (r_state == M_SRC_RD) ? 8'(r_i) : 8'(r_j[IW-1:0]);
        o_req.map_wr_en = (r_state == M_WRITE);
        o_req.map_addr  = 8'(r_i);
        o_req.map_data  = 8'(r_pick);
        o_req.done      = (r_state == M_WRITE) && (r_i == TOP_LVL);
    end

    assign o_busy = (r_state != M_IDLE);

    // Sequencer over source rows plus the reference scan pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= M_IDLE;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_i     <= '0;
                        r_accs  <= '0;
                        r_state <= M_SRC_RD;
                    end
                end
                M_SRC_RD: begin
                    r_state <= M_SRC_ACC;
                end
                M_SRC_ACC: begin
                    r_accs  <= n_accs;
                    r_state <= M_A_MUL;
                end
                M_A_MUL: begin
                    r_a     <= {{CW{1'b0}}, r_accs} * {{CW{1'b0}}, i_nr};
                    r_accr  <= '0;
                    r_j     <= '0;
                    r_state <= M_SCAN;
                end
                M_SCAN: begin
                    if (r_j == J_END && !r_p1_vld && !r_p2_vld && !r_p3_vld) begin
                        r_state <= M_WRITE;
                    end
                end
                M_WRITE: begin
                    if (r_i == TOP_LVL) begin
                        r_state <= M_IDLE;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= M_SRC_RD;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase

            // Issue one reference read per cycle
            r_p1_vld <= issue;
            if (issue) begin
                r_j    <= r_j + JW'(1);
                r_p1_j <= r_j[IW-1:0];
            end

            // Accumulate the reference CDF
            r_p2_vld <= r_p1_vld;
            if (r_p1_vld) begin
                r_accr <= n_accr;
                r_p2_j <= r_p1_j;
            end

            // Scale the reference CDF by the source total
            r_p3_vld <= r_p2_vld;
            if (r_p2_vld) begin
                r_b    <= {{CW{1'b0}}, r_accr} * {{CW{1'b0}}, i_ns};
                r_p3_j <= r_p2_j;
            end

            // Keep the closest level, lowest on ties
            if (r_p3_vld && better) begin
                r_best <= diff;
                r_pick <= r_p3_j;
            end
        end
    end

    `HSL_ASSERT_NOW(a_write_drained, i_clk, i_rst_n, r_state == M_WRITE,
        !r_p1_vld && !r_p2_vld && !r_p3_vld, "row written before scan pipeline drained")
    `HSL_ASSERT_NEXT(a_scan_stops, i_clk, i_rst_n, r_state == M_SCAN && r_j == J_END,
        !r_p1_vld, "reference read issued past last level")
    `HSL_ASSERT_NOW(a_acc_after_read, i_clk, i_rst_n, r_state == M_SRC_ACC,
        $past(r_state) == M_SRC_RD, "source count used without a read")

endmodule

[tb/sv/hsl_lut_checker.sv]
// Checker for the histogram specification block: mirrors histograms and lookup table.
// Watches both channels, predicts each map result and compares it. Depends on hsl_pkg.
module hsl_lut_checker
    import hsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_mismatches,
    output int        o_waiting
);

    localparam longint unsigned COUNT_TOP = (64'd1 << HSL_COUNT_BITS) - 1;
    localparam int REPORT_LIMIT = 10;

    typedef logic [HSL_COUNT_BITS-1:0] t_count;

    t_count     src_bins [HSL_NUM_LEVELS];
    t_count     ref_bins [HSL_NUM_LEVELS];
    t_count     src_sum;
    t_count     ref_sum;
    logic [7:0] lut [HSL_NUM_LEVELS];
    logic       lut_built;
    t_out_item  due_mappings [$];
    t_out_item  want;
    int         mismatch_count = 0;

    // Saturating increment of one bin or total
    function automatic t_count bump(t_count v);
        return (longint'(v) >= COUNT_TOP) ? v : v + 1'b1;
    endfunction

    // Empty histograms and totals and clear the built flag; the lookup table keeps its entries
    function automatic void clear_counts();
        for (int i = 0; i < HSL_NUM_LEVELS; i++) begin
            src_bins[i] = '0;
            ref_bins[i] = '0;
        end
        src_sum   = '0;
        ref_sum   = '0;
        lut_built = 1'b0;
    endfunction

    function automatic void reset_model();
        clear_counts();
        for (int i = 0; i < HSL_NUM_LEVELS; i++) begin
            lut[i] = 8'(i);
        end
        due_mappings.delete();
    endfunction

    // Match cumulative counts exactly: minimize |Cs(i)*Nr - Cr(j)*Ns|, lowest j on ties
    function automatic void rebuild_lut();
        longint unsigned cum_src [HSL_NUM_LEVELS];
        longint unsigned cum_ref [HSL_NUM_LEVELS];
        longint unsigned run_src;
        longint unsigned run_ref;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned gap;
        longint unsigned best;
        int              pick;
        run_src = 0;
        run_ref = 0;
        for (int i = 0; i < HSL_NUM_LEVELS; i++) begin
            run_src = run_src + longint'(src_bins[i]);
            run_ref = run_ref + longint'(ref_bins[i]);
            if (run_src > COUNT_TOP) run_src = COUNT_TOP;
            if (run_ref > COUNT_TOP) run_ref = COUNT_TOP;
            cum_src[i] = run_src;
            cum_ref[i] = run_ref;
        end
        for (int i = 0; i < HSL_NUM_LEVELS; i++) begin
            lhs  = cum_src[i] * longint'(ref_sum);
            best = 0;
            pick = 0;
            for (int j = 0; j < HSL_NUM_LEVELS; j++) begin
                rhs = cum_ref[j] * longint'(src_sum);
                gap = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
                if (j == 0 || gap < best) begin
                    best = gap;
                    pick = j;
                end
            end
            lut[i] = 8'(pick);
        end
        lut_built = 1'b1;
    endfunction

    // Advance the mirrored state by one accepted input transfer
    function automatic void absorb_item(t_in_item item);
        int        lvl;
        t_out_item res;
        lvl = (int'(item.sample) > HSL_NUM_LEVELS - 1) ? HSL_NUM_LEVELS - 1
                                                       : int'(item.sample);
        case (item.kind)
            K_LOAD_SRC: begin
                src_bins[lvl] = bump(src_bins[lvl]);
                src_sum       = bump(src_sum);
            end
            K_LOAD_REF: begin
                ref_bins[lvl] = bump(ref_bins[lvl]);
                ref_sum       = bump(ref_sum);
            end
            K_BUILD: rebuild_lut();
            K_MAP: begin
                res.mapped_sample = lut[lvl];
                res.table_built   = lut_built;
                due_mappings.push_back(res);
            end
            K_CLEAR: clear_counts();
            default: ;
        endcase
    endfunction

    initial reset_model();

    // Check the output transfer first: a map result never leaves in its own transfer cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_mappings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result mapped_sample %0d table_built %0d",
                                 $time, i_out_item.mapped_sample, i_out_item.table_built);
                    end
                end else begin
                    want = due_mappings.pop_front();
                    if (i_out_item.mapped_sample !== want.mapped_sample ||
                        i_out_item.table_built !== want.table_built) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: mapped_sample exp %0d got %0d, table_built exp %0d got %0d",
                                     $time, want.mapped_sample, i_out_item.mapped_sample,
                                     want.table_built, i_out_item.table_built);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_item(i_in_item);
            end
        end
        o_mismatches = mismatch_count;
        o_waiting    = due_mappings.size();
    end

endmodule

[tb/sv/tb_histogram_specification_lut_core.sv]
// Testbench top for histogram_specification_lut_core: clock, reset, stimulus, verdict.
// Depends on hsl_pkg, the block and hsl_lut_checker.
module tb_histogram_specification_lut_core;
    import hsl_pkg::*;

    localparam int         RANDOM_ITEMS = 527;
    localparam int         CALM_TAIL    = 60;
    localparam int         BUILD_BUDGET = 7;
    localparam int         DRAIN_CYCLES = 16;
    localparam longint     CYCLE_LIMIT  = 4000000;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;
    int        mismatches;
    int        waiting;
    longint    cycles    = 0;
    bit        idle_on   = 1'b0;
    bit        calm      = 1'b0;
    int        stall_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    histogram_specification_lut_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    hsl_lut_checker lut_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    // Abort a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_histogram_specification_lut_core failed");
            $finish;
        end
    end

    // Stall the result channel in bursts of random length
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
        end
        out_ready <= (stall_left == 0);
    end

    // Present one item, with an optional idle burst ahead, and hold it until its transfer
    task automatic send_item(input logic [2:0] kind, input logic [7:0] sample);
        t_in_item item;
        int       gap;
        item.kind   = kind;
        item.sample = sample;
        gap = (idle_on && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // Pick a level around a center, clamped to the sample range
    function automatic logic [7:0] near_level(int center, int spread);
        int v;
        v = center + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic logic [2:0] spare_kind();
        return 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    endfunction

    initial begin
        int counted;
        int builds_left;
        int src_center;
        int src_spread;
        int ref_center;
        int ref_spread;
        int load_mix;
        int n;
        bit to_ref;
        logic [7:0] smp;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: identity table, unused kinds, empty build, small build, clear
        idle_on = 1'b1;
        send_item(K_MAP, 8'h00);
        send_item(K_MAP, 8'hff);
        send_item(KIND_SPARE_LO, 8'haa);
        send_item(3'd6, 8'h55);
        send_item(KIND_SPARE_HI, 8'hff);
        send_item(K_BUILD, 8'h00);
        send_item(K_MAP, 8'd200);
        send_item(K_LOAD_SRC, 8'h00);
        send_item(K_LOAD_SRC, 8'hff);
        send_item(K_LOAD_SRC, 8'd128);
        send_item(K_LOAD_REF, 8'hff);
        send_item(K_LOAD_REF, 8'h00);
        send_item(K_LOAD_REF, 8'd64);
        send_item(K_BUILD, 8'hff);
        send_item(K_MAP, 8'h00);
        send_item(K_MAP, 8'd128);
        send_item(K_MAP, 8'hff);
        send_item(K_MAP, 8'd77);
        send_item(K_CLEAR, 8'h00);
        send_item(K_MAP, 8'd128);
        // Reference only: source total stays zero
        send_item(K_LOAD_REF, 8'd10);
        send_item(K_BUILD, 8'h00);
        send_item(K_MAP, 8'd99);

        // Random episodes: clear, loads with shaped distributions, build, maps
        counted     = 0;
        builds_left = BUILD_BUDGET;
        while (counted < RANDOM_ITEMS) begin
            idle_on    = ($urandom_range(0, 3) != 0);
            calm       = (counted >= RANDOM_ITEMS - CALM_TAIL);
            src_center = $urandom_range(0, 255);
            src_spread = $urandom_range(0, 60);
            ref_center = $urandom_range(0, 255);
            ref_spread = $urandom_range(0, 60);
            load_mix   = $urandom_range(0, 5);
            if ($urandom_range(0, 3) != 0) begin
                send_item(K_CLEAR, 8'($urandom));
                counted++;
            end
            n = $urandom_range(8, 48);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) send_item(spare_kind(), 8'($urandom));
                to_ref = (load_mix == 0) ? 1'b0 : (load_mix == 1) ? 1'b1 : 1'($urandom);
                if ($urandom_range(0, 7) == 0) smp = 8'($urandom);
                else if (to_ref) smp = near_level(ref_center, ref_spread);
                else smp = near_level(src_center, src_spread);
                send_item(to_ref ? K_LOAD_REF : K_LOAD_SRC, smp);
                counted++;
            end
            if (builds_left > 0 && $urandom_range(0, 3) != 0) begin
                send_item(K_BUILD, 8'($urandom));
                builds_left--;
                counted++;
            end
            n = $urandom_range(6, 28);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) send_item(spare_kind(), 8'($urandom));
                if ($urandom_range(0, 39) == 0) begin
                    send_item(K_CLEAR, 8'($urandom));
                    counted++;
                end
                smp = $urandom_range(0, 1) ? near_level(src_center, src_spread)
                                           : 8'($urandom);
                send_item(K_MAP, smp);
                counted++;
            end
        end

        // Drain outstanding results, then give the verdict
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && waiting == 0) begin
            $display("tb_histogram_specification_lut_core passed");
        end else begin
            $display("tb_histogram_specification_lut_core failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/hsl_pkg.sv
rtl/hsl_ram.sv
rtl/hsl_match.sv
rtl/histogram_specification_lut_core.sv
tb/sv/hsl_lut_checker.sv
tb/sv/tb_histogram_specification_lut_core.sv
